// ----- design/imu_fall_detector_hysteresis_assert.svh -----
// assertion helpers for the fall detector
`ifndef IMU_FALL_DETECTOR_HYSTERESIS_ASSERT_SVH
`define IMU_FALL_DETECTOR_HYSTERESIS_ASSERT_SVH

// property must hold at every rising clock edge outside reset
`define IMU_FD_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// condition must never be seen outside reset
`define IMU_FD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `IMU_FD_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ----- design/imu_fd_pkg.sv -----
package imu_fd_pkg;

  localparam int unsigned ACCEL_W    = 16;
  localparam int unsigned COS_W      = 16;
  localparam int unsigned MAG_W      = 16;
  localparam int unsigned SQ_W       = 32;
  localparam int unsigned PRIO_W     = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // first trial bit of the 32 bit integer square root
  localparam logic [SQ_W-1:0] SQRT_BIT_TOP = 32'h4000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FALL_COS    = 3'd0,
    REG_FALL_ACCEL  = 3'd1,
    REG_REC_COS     = 3'd2,
    REG_REC_LOW     = 3'd3,
    REG_REC_HIGH    = 3'd4,
    REG_FALL_PRIO   = 3'd5
  } cfg_reg_e;

  localparam logic signed [COS_W-1:0] FALL_COS_RST   = 16'sd8192;
  localparam logic [MAG_W-1:0]        FALL_ACCEL_RST = 16'd1280;
  localparam logic signed [COS_W-1:0] REC_COS_RST    = 16'sd13000;
  localparam logic [MAG_W-1:0]        REC_LOW_RST    = 16'd2304;
  localparam logic [MAG_W-1:0]        REC_HIGH_RST   = 16'd2816;
  localparam logic [PRIO_W-1:0]       FALL_PRIO_RST  = 8'd100;

endpackage

// ----- design/imu_fd_if.sv -----
interface imu_fd_sample_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [imu_fd_pkg::ACCEL_W-1:0]     accel_x;
  logic signed [imu_fd_pkg::ACCEL_W-1:0]     accel_y;
  logic signed [imu_fd_pkg::ACCEL_W-1:0]     accel_z;
  logic signed [imu_fd_pkg::COS_W-1:0]       tilt_cos;

  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  output tilt_cos, input ready);
  modport sink   (input valid, input accel_x, input accel_y, input accel_z,
                  input tilt_cos, output ready);
endinterface

interface imu_fd_result_if;
  logic                              valid;
  logic                              ready;
  logic                              is_falling;
  logic                              priority_valid;
  logic [imu_fd_pkg::PRIO_W-1:0]     priority_level;
  logic [imu_fd_pkg::MAG_W-1:0]      short_mean;

  modport source (output valid, output is_falling, output priority_valid,
                  output priority_level, output short_mean, input ready);
  modport sink   (input valid, input is_falling, input priority_valid,
                  input priority_level, input short_mean, output ready);
endinterface

// ----- design/imu_fall_detector_hysteresis.sv -----
// fall detector with hysteresis on an imu sample stream
// sample_i carries one beat per imu sample: three signed q8.8 accelerometer
// components and the q1.14 tilt cosine. result_o returns exactly one beat per
// sample: the falling flag, a priority announcement when a fall or a recovery
// fires, and the q8.8 short-window mean magnitude.
// cfg port: write limits by register index while no sample is in flight;
// cfg_ready_o is always high and unknown indexes are dropped.
// sequence: one sample occupies the shared datapath through the
// multiply-accumulate, square root, ring update, bit-serial divider (short then
// long mean) and decide steps; the result beat goes valid on the cycle after the
// decide step, the same cycle the next sample can be taken, so a new sample is
// taken only once the previous one has left the decide step. The bit-serial
// divider and the square root produce one result bit per cycle.
// a stalled result sits in the output register; a finished sample waits in
// the decide step until that register frees up, and no new sample is taken.
// reset clears the ring fill level, running sums, falling flag and limits
// to their defaults; no ring clearing pass is needed.
`include "imu_fall_detector_hysteresis_assert.svh"

module imu_fall_detector_hysteresis #(
  parameter int unsigned SHORT_WINDOW = 5,
  parameter int unsigned LONG_WINDOW  = 200
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  imu_fd_sample_if.sink                        sample_i,
  imu_fd_result_if.source                      result_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [imu_fd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [imu_fd_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned ACCEL_W = imu_fd_pkg::ACCEL_W;
  localparam int unsigned COS_W   = imu_fd_pkg::COS_W;
  localparam int unsigned MAG_W   = imu_fd_pkg::MAG_W;
  localparam int unsigned SQ_W    = imu_fd_pkg::SQ_W;
  localparam int unsigned PRIO_W  = imu_fd_pkg::PRIO_W;

  localparam int unsigned RING_LEN =
    (SHORT_WINDOW > LONG_WINDOW) ? SHORT_WINDOW : LONG_WINDOW;
  localparam int unsigned SLOT_W  = $clog2(RING_LEN);
  localparam int unsigned SLOT_XW = SLOT_W + 1;
  localparam int unsigned CNT_W   = $clog2(RING_LEN + 1);
  localparam int unsigned SSUM_W  = MAG_W + $clog2(SHORT_WINDOW + 1);
  localparam int unsigned LSUM_W  = MAG_W + $clog2(LONG_WINDOW + 1);
  localparam int unsigned DIV_W   = (SSUM_W > LSUM_W) ? SSUM_W : LSUM_W;
  localparam int unsigned DCNT_W  = $clog2(DIV_W + 1);
  localparam int unsigned N_AXES  = 3;

  localparam logic [1:0]         MUL_LAST = 2'(N_AXES - 1);
  localparam logic [SLOT_W:0]    S_OFF    = SLOT_XW'(SHORT_WINDOW);
  localparam logic [SLOT_W:0]    S_WRAP   = SLOT_XW'(RING_LEN - SHORT_WINDOW);
  localparam logic [SLOT_W:0]    L_OFF    = SLOT_XW'(LONG_WINDOW);
  localparam logic [SLOT_W:0]    L_WRAP   = SLOT_XW'(RING_LEN - LONG_WINDOW);
  localparam logic [SLOT_W-1:0]  SLOT_TOP = SLOT_W'(RING_LEN - 1);
  localparam logic [CNT_W-1:0]   S_CNT    = CNT_W'(SHORT_WINDOW);
  localparam logic [CNT_W-1:0]   L_CNT    = CNT_W'(LONG_WINDOW);
  localparam logic [CNT_W-1:0]   RING_CNT = CNT_W'(RING_LEN);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_MUL    = 7'b0000010,
    ST_SQRT   = 7'b0000100,
    ST_UPD    = 7'b0001000,
    ST_DIVS   = 7'b0010000,
    ST_DIVL   = 7'b0100000,
    ST_DECIDE = 7'b1000000
  } state_e;

  function automatic logic [ACCEL_W-1:0] abs_val(input logic signed [ACCEL_W-1:0] v);
    abs_val = v[ACCEL_W-1] ? ACCEL_W'(-v) : ACCEL_W'(v);
  endfunction

  state_e                     state_q, state_d;
  logic [1:0]                 step_q, step_d;
  logic [SLOT_W-1:0]          slot_q, slot_d;
  logic [CNT_W-1:0]           fill_q, fill_d;
  logic [SSUM_W-1:0]          ssum_q, ssum_d;
  logic [LSUM_W-1:0]          lsum_q, lsum_d;
  logic                       fallen_q, fallen_d;
  logic                       res_valid_q, res_valid_d;

  logic signed [COS_W-1:0]    fall_cos_q, rec_cos_q;
  logic [MAG_W-1:0]           fall_accel_q, rec_low_q, rec_high_q;
  logic [PRIO_W-1:0]          fall_prio_q;

  logic [ACCEL_W-1:0]         ax_q, ay_q, az_q;
  logic signed [COS_W-1:0]    tilt_q;
  logic [SQ_W-1:0]            sq_q, root_q, bit_q;
  logic [MAG_W-1:0]           ring_mem [RING_LEN];
  logic [MAG_W-1:0]           rd_q, old_s_q;
  logic [DIV_W-1:0]           div_num_q;
  logic [CNT_W-1:0]           div_rem_q, div_den_q;
  logic [DCNT_W-1:0]          div_cnt_q;
  logic [MAG_W-1:0]           short_mean_q;
  logic [LSUM_W-1:0]          long_mean_q;

  logic                       res_falling_q, res_pv_q;
  logic [PRIO_W-1:0]          res_level_q;
  logic [MAG_W-1:0]           res_mean_q;

  // shared multiply-accumulate
  logic [ACCEL_W-1:0]         mul_op;
  logic [SQ_W-1:0]            prod, sq_acc;
  // square root step
  logic [SQ_W-1:0]            trial;
  logic                       take;
  // ring addressing and sum update
  logic [SLOT_W:0]            slot_ext, addr_s_ext, addr_l_ext;
  logic [SLOT_W-1:0]          rd_addr, slot_nx;
  logic [MAG_W-1:0]           mag, s_sub, l_sub;
  logic [SSUM_W-1:0]          ssum_upd;
  logic [LSUM_W-1:0]          lsum_upd;
  logic [CNT_W-1:0]           fill_inc, short_n, long_n;
  // divider step
  logic [CNT_W:0]             rem_sh, rem_sub;
  logic                       div_ge, div_last;
  logic [CNT_W-1:0]           rem_nx;
  logic [DIV_W-1:0]           num_nx, num_s_load, num_l_load;
  logic [MAG_W-1:0]           short_sat;
  // decision
  logic                       fall_hit, rec_hit, flag_mid, out_free;

  always_comb begin
    case (step_q)
      2'd0:    mul_op = ax_q;
      2'd1:    mul_op = ay_q;
      default: mul_op = az_q;
    endcase
  end
  assign prod   = SQ_W'(mul_op) * SQ_W'(mul_op);
  assign sq_acc = ((step_q == 2'd0) ? '0 : sq_q) + prod;

  assign trial = root_q + bit_q;
  assign take  = sq_q >= trial;

  assign slot_ext   = {1'b0, slot_q};
  assign addr_s_ext = (slot_ext >= S_OFF) ? slot_ext - S_OFF : slot_ext + S_WRAP;
  assign addr_l_ext = (slot_ext >= L_OFF) ? slot_ext - L_OFF : slot_ext + L_WRAP;
  // short-window tap is read on the first multiply step, long tap after it
  assign rd_addr    = (state_q == ST_MUL && step_q == 2'd0) ? addr_s_ext[SLOT_W-1:0]
                                                            : addr_l_ext[SLOT_W-1:0];
  assign slot_nx    = (slot_q == SLOT_TOP) ? '0 : slot_q + SLOT_W'(1);

  assign mag      = root_q[MAG_W-1:0];
  assign s_sub    = (fill_q >= S_CNT) ? old_s_q : '0;
  assign l_sub    = (fill_q >= L_CNT) ? rd_q : '0;
  assign ssum_upd = ssum_q - SSUM_W'(s_sub) + SSUM_W'(mag);
  assign lsum_upd = lsum_q - LSUM_W'(l_sub) + LSUM_W'(mag);
  assign fill_inc = (fill_q < RING_CNT) ? fill_q + CNT_W'(1) : fill_q;
  assign short_n  = (fill_inc < S_CNT) ? fill_inc : S_CNT;
  assign long_n   = (fill_q < L_CNT) ? fill_q : L_CNT;

  // restoring divider, one quotient bit per cycle, numerator left aligned
  assign rem_sh     = {div_rem_q, div_num_q[DIV_W-1]};
  assign rem_sub    = rem_sh - {1'b0, div_den_q};
  assign div_ge     = rem_sh >= {1'b0, div_den_q};
  assign rem_nx     = div_ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
  assign num_nx     = {div_num_q[DIV_W-2:0], div_ge};
  assign div_last   = div_cnt_q == DCNT_W'(1);
  assign num_s_load = DIV_W'(ssum_upd) << (DIV_W - SSUM_W);
  assign num_l_load = DIV_W'(lsum_q) << (DIV_W - LSUM_W);
  assign short_sat  = (|num_nx[SSUM_W-1:MAG_W]) ? '1 : num_nx[MAG_W-1:0];

  // fall check first, recovery check sees its outcome
  assign fall_hit = !fallen_q && (tilt_q < fall_cos_q) && (short_mean_q < fall_accel_q);
  assign flag_mid = fallen_q || fall_hit;
  assign rec_hit  = flag_mid && (tilt_q > rec_cos_q)
                    && (long_mean_q > LSUM_W'(rec_low_q))
                    && (long_mean_q < LSUM_W'(rec_high_q));
  assign out_free = !res_valid_q || result_o.ready;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    slot_d      = slot_q;
    fill_d      = fill_q;
    ssum_d      = ssum_q;
    lsum_d      = lsum_q;
    fallen_d    = fallen_q;
    res_valid_d = res_valid_q && !result_o.ready;
    case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          state_d = ST_MUL;
          step_d  = '0;
        end
      end
      ST_MUL: begin
        step_d = step_q + 2'd1;
        if (step_q == MUL_LAST) begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (bit_q[0]) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        ssum_d  = ssum_upd;
        lsum_d  = lsum_upd;
        fill_d  = fill_inc;
        slot_d  = slot_nx;
        state_d = ST_DIVS;
      end
      ST_DIVS: begin
        if (div_last) begin
          state_d = ST_DIVL;
        end
      end
      ST_DIVL: begin
        if (div_last) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          fallen_d    = flag_mid && !rec_hit;
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      step_q       <= '0;
      slot_q       <= '0;
      fill_q       <= '0;
      ssum_q       <= '0;
      lsum_q       <= '0;
      fallen_q     <= 1'b0;
      res_valid_q  <= 1'b0;
      fall_cos_q   <= imu_fd_pkg::FALL_COS_RST;
      fall_accel_q <= imu_fd_pkg::FALL_ACCEL_RST;
      rec_cos_q    <= imu_fd_pkg::REC_COS_RST;
      rec_low_q    <= imu_fd_pkg::REC_LOW_RST;
      rec_high_q   <= imu_fd_pkg::REC_HIGH_RST;
      fall_prio_q  <= imu_fd_pkg::FALL_PRIO_RST;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      slot_q      <= slot_d;
      fill_q      <= fill_d;
      ssum_q      <= ssum_d;
      lsum_q      <= lsum_d;
      fallen_q    <= fallen_d;
      res_valid_q <= res_valid_d;
      if (cfg_valid_i) begin
        case (imu_fd_pkg::cfg_reg_e'(cfg_index_i))
          imu_fd_pkg::REG_FALL_COS:   fall_cos_q   <= cfg_data_i;
          imu_fd_pkg::REG_FALL_ACCEL: fall_accel_q <= cfg_data_i;
          imu_fd_pkg::REG_REC_COS:    rec_cos_q    <= cfg_data_i;
          imu_fd_pkg::REG_REC_LOW:    rec_low_q    <= cfg_data_i;
          imu_fd_pkg::REG_REC_HIGH:   rec_high_q   <= cfg_data_i;
          imu_fd_pkg::REG_FALL_PRIO:  fall_prio_q  <= cfg_data_i[PRIO_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // magnitude ring, at most one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPD) begin
      ring_mem[slot_q] <= mag;
    end
    rd_q <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          ax_q   <= abs_val(sample_i.accel_x);
          ay_q   <= abs_val(sample_i.accel_y);
          az_q   <= abs_val(sample_i.accel_z);
          tilt_q <= sample_i.tilt_cos;
        end
      end
      ST_MUL: begin
        sq_q <= sq_acc;
        if (step_q == 2'd1) begin
          old_s_q <= rd_q;
        end
        if (step_q == MUL_LAST) begin
          root_q <= '0;
          bit_q  <= imu_fd_pkg::SQRT_BIT_TOP;
        end
      end
      ST_SQRT: begin
        if (take) begin
          sq_q   <= sq_q - trial;
          root_q <= (root_q >> 1) + bit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      ST_UPD: begin
        div_num_q <= num_s_load;
        div_rem_q <= '0;
        div_den_q <= short_n;
        div_cnt_q <= DCNT_W'(SSUM_W);
      end
      ST_DIVS: begin
        if (div_last) begin
          short_mean_q <= short_sat;
          div_num_q    <= num_l_load;
          div_rem_q    <= '0;
          div_den_q    <= long_n;
          div_cnt_q    <= DCNT_W'(LSUM_W);
        end else begin
          div_num_q <= num_nx;
          div_rem_q <= rem_nx;
          div_cnt_q <= div_cnt_q - DCNT_W'(1);
        end
      end
      ST_DIVL: begin
        div_num_q <= num_nx;
        div_rem_q <= rem_nx;
        div_cnt_q <= div_cnt_q - DCNT_W'(1);
        if (div_last) begin
          long_mean_q <= num_nx[LSUM_W-1:0];
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          res_falling_q <= flag_mid && !rec_hit;
          res_pv_q      <= fall_hit || rec_hit;
          res_level_q   <= rec_hit ? '0 : (fall_hit ? fall_prio_q : '0);
          res_mean_q    <= short_mean_q;
        end
      end
      default: ;
    endcase
  end

  assign sample_i.ready          = (state_q == ST_IDLE);
  assign cfg_ready_o             = 1'b1;
  assign result_o.valid          = res_valid_q;
  assign result_o.is_falling     = res_falling_q;
  assign result_o.priority_valid = res_pv_q;
  assign result_o.priority_level = res_level_q;
  assign result_o.short_mean     = res_mean_q;

  `IMU_FD_ASSERT_NEVER(a_fill_range, clk_i, rst_ni, fill_q > RING_CNT, "ring fill overrun")
  `IMU_FD_ASSERT(a_div_den, clk_i, rst_ni, (state_q == ST_DIVS || state_q == ST_DIVL) |-> div_den_q != '0, "divider started with zero count")
  `IMU_FD_ASSERT(a_flag_change, clk_i, rst_ni, (fallen_q != $past(fallen_q)) |-> $past(state_q == ST_DECIDE), "falling flag moved outside decide step")
  `IMU_FD_ASSERT(a_result_rise, clk_i, rst_ni, $rose(res_valid_q) |-> $past(state_q == ST_DECIDE), "result beat raised outside decide step")

endmodule

// ----- tb/tb_imu_fall_detector_hysteresis.sv -----
`timescale 1ns / 100ps

module tb_imu_fall_detector_hysteresis;

  localparam int unsigned ACCEL_W      = imu_fd_pkg::ACCEL_W;
  localparam int unsigned COS_W        = imu_fd_pkg::COS_W;
  localparam int unsigned MAG_W        = imu_fd_pkg::MAG_W;
  localparam int unsigned PRIO_W       = imu_fd_pkg::PRIO_W;
  localparam int unsigned CFG_IDX_W    = imu_fd_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W   = imu_fd_pkg::CFG_DATA_W;

  localparam int unsigned SHORT_N      = 5;
  localparam int unsigned LONG_N       = 200;
  localparam int unsigned RING_LEN     = (SHORT_N > LONG_N) ? SHORT_N : LONG_N;
  localparam int unsigned CYCLE_CAP    = 400000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 82;

  // indexes past the last limit register, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum int {RUN_UPRIGHT, RUN_FREE_FALL, RUN_LYING, RUN_NOISE} run_kind_e;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] ax;
    logic signed [ACCEL_W-1:0] ay;
    logic signed [ACCEL_W-1:0] az;
    logic signed [COS_W-1:0]   tilt;
  } sample_t;

  typedef struct packed {
    logic              falling;
    logic              announce;
    logic [PRIO_W-1:0] level;
    logic [MAG_W-1:0]  mean;
  } verdict_t;

  typedef struct packed {
    logic                  is_write;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    sample_t               smp_v;
    logic                  typed;
    verdict_t              want;
  } row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  imu_fd_sample_if smp ();
  imu_fd_result_if res ();

  imu_fall_detector_hysteresis #(
    .SHORT_WINDOW(SHORT_N),
    .LONG_WINDOW (LONG_N)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .sample_i   (smp),
    .result_o   (res),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // detector model state
  logic [MAG_W-1:0]        mag_ring [RING_LEN];
  int unsigned             write_pos;
  int unsigned             held;
  int unsigned             short_acc;
  int unsigned             long_acc;
  logic                    fallen;
  logic signed [COS_W-1:0] lim_fall_cos;
  logic [MAG_W-1:0]        lim_fall_accel;
  logic signed [COS_W-1:0] lim_rec_cos;
  logic [MAG_W-1:0]        lim_rec_low;
  logic [MAG_W-1:0]        lim_rec_high;
  logic [PRIO_W-1:0]       prio_fall;

  verdict_t    pending_verdicts [$];
  int unsigned mismatches;
  int unsigned n_samples;
  int unsigned n_writes;
  int unsigned n_falls;
  int unsigned n_recoveries;
  bit          gap_on;

  function automatic void reset_model();
    write_pos      = 0;
    held           = 0;
    short_acc      = 0;
    long_acc       = 0;
    fallen         = 1'b0;
    lim_fall_cos   = imu_fd_pkg::FALL_COS_RST;
    lim_fall_accel = imu_fd_pkg::FALL_ACCEL_RST;
    lim_rec_cos    = imu_fd_pkg::REC_COS_RST;
    lim_rec_low    = imu_fd_pkg::REC_LOW_RST;
    lim_rec_high   = imu_fd_pkg::REC_HIGH_RST;
    prio_fall      = imu_fd_pkg::FALL_PRIO_RST;
  endfunction

  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    case (idx)
      imu_fd_pkg::REG_FALL_COS:   lim_fall_cos = data;
      imu_fd_pkg::REG_FALL_ACCEL: lim_fall_accel = data;
      imu_fd_pkg::REG_REC_COS:    lim_rec_cos = data;
      imu_fd_pkg::REG_REC_LOW:    lim_rec_low = data;
      imu_fd_pkg::REG_REC_HIGH:   lim_rec_high = data;
      imu_fd_pkg::REG_FALL_PRIO:  prio_fall = data[PRIO_W-1:0];
      default: ;
    endcase
  endfunction

  // floor of the euclidean norm, built one result bit at a time
  function automatic logic [MAG_W-1:0] magnitude_of(input sample_t s);
    longint energy;
    longint root;
    longint cand;
    energy = longint'(s.ax) * longint'(s.ax) + longint'(s.ay) * longint'(s.ay)
           + longint'(s.az) * longint'(s.az);
    root = 0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      cand = root | (longint'(1) << b);
      if (cand * cand <= energy) root = cand;
    end
    return MAG_W'(root);
  endfunction

  function automatic verdict_t predict_verdict(input sample_t s);
    verdict_t    v;
    logic [MAG_W-1:0] mag;
    int unsigned short_cnt;
    int unsigned long_cnt;
    int unsigned short_mean;
    int unsigned long_mean;
    mag = magnitude_of(s);
    if (held >= SHORT_N)
      short_acc -= 32'(mag_ring[(write_pos + RING_LEN - SHORT_N) % RING_LEN]);
    if (held >= LONG_N)
      long_acc -= 32'(mag_ring[(write_pos + RING_LEN - LONG_N) % RING_LEN]);
    mag_ring[write_pos] = mag;
    short_acc += 32'(mag);
    long_acc  += 32'(mag);
    write_pos = (write_pos + 1) % RING_LEN;
    if (held < RING_LEN) held++;
    short_cnt  = (held < SHORT_N) ? held : SHORT_N;
    long_cnt   = (held < LONG_N) ? held : LONG_N;
    short_mean = short_acc / short_cnt;
    long_mean  = long_acc / long_cnt;
    if (short_mean > 32'hFFFF) short_mean = 32'hFFFF;
    v = '0;
    v.mean = MAG_W'(short_mean);
    if (!fallen && s.tilt < lim_fall_cos && short_mean < 32'(lim_fall_accel)) begin
      fallen     = 1'b1;
      v.announce = 1'b1;
      v.level    = prio_fall;
      n_falls++;
    end
    // recovery is checked on the updated flag, so both can fire on one sample
    if (fallen && s.tilt > lim_rec_cos && long_mean > 32'(lim_rec_low)
        && long_mean < 32'(lim_rec_high)) begin
      fallen     = 1'b0;
      v.announce = 1'b1;
      v.level    = '0;
      n_recoveries++;
    end
    v.falling = fallen;
    return v;
  endfunction

  function automatic int between(input int lo, input int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic sample_t make_sample(input run_kind_e kind);
    sample_t s;
    case (kind)
      RUN_UPRIGHT: begin
        s.ax   = 16'(between(-300, 300));
        s.ay   = 16'(between(-300, 300));
        s.az   = 16'(between(2410, 2710));
        s.tilt = 16'(between(13001, 16384));
        if ($urandom_range(1) == 1) s.az = -s.az;
      end
      RUN_FREE_FALL: begin
        s.ax   = 16'(between(-400, 400));
        s.ay   = 16'(between(-400, 400));
        s.az   = 16'(between(-400, 400));
        s.tilt = 16'(between(-16384, 8191));
      end
      RUN_LYING: begin
        s.ax   = 16'(between(2410, 2710));
        s.ay   = 16'(between(-300, 300));
        s.az   = 16'(between(-300, 300));
        s.tilt = 16'(between(-3000, 3000));
        if ($urandom_range(1) == 1) s.ax = -s.ax;
      end
      default: begin
        s.ax   = 16'($urandom);
        s.ay   = 16'($urandom);
        s.az   = 16'($urandom);
        s.tilt = 16'($urandom);
      end
    endcase
    return s;
  endfunction

  function automatic row_t sample_row(input int ax, input int ay, input int az,
                                      input int tilt);
    row_t r;
    r = '0;
    r.smp_v.ax   = 16'(ax);
    r.smp_v.ay   = 16'(ay);
    r.smp_v.az   = 16'(az);
    r.smp_v.tilt = 16'(tilt);
    return r;
  endfunction

  function automatic row_t checked_row(input int ax, input int ay, input int az,
                                       input int tilt, input int falling,
                                       input int announce, input int level,
                                       input int mean);
    row_t r;
    r = sample_row(ax, ay, az, tilt);
    r.typed         = 1'b1;
    r.want.falling  = 1'(falling);
    r.want.announce = 1'(announce);
    r.want.level    = 8'(level);
    r.want.mean     = 16'(mean);
    return r;
  endfunction

  function automatic row_t write_row(input logic [CFG_IDX_W-1:0] idx, input int data);
    row_t r;
    r = '0;
    r.is_write = 1'b1;
    r.idx      = idx;
    r.data     = 16'(data);
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  // lets every sample in flight drain before the limits change
  task automatic wait_idle();
    smp.valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_write(idx, data);
    n_writes++;
    @(negedge clk_i);
  endtask

  task automatic program_limits(input logic [15:0] fall_cos, input logic [15:0] fall_acc,
                                input logic [15:0] rec_cos, input logic [15:0] rec_low,
                                input logic [15:0] rec_high, input logic [15:0] prio);
    write_reg(imu_fd_pkg::REG_FALL_COS, fall_cos);
    write_reg(imu_fd_pkg::REG_FALL_ACCEL, fall_acc);
    write_reg(imu_fd_pkg::REG_REC_COS, rec_cos);
    write_reg(imu_fd_pkg::REG_REC_LOW, rec_low);
    write_reg(imu_fd_pkg::REG_REC_HIGH, rec_high);
    write_reg(imu_fd_pkg::REG_FALL_PRIO, prio);
    cfg_valid_i <= 1'b0;
  endtask

  // entered and left on a falling edge
  task automatic put_sample(input sample_t s, input logic typed, input verdict_t want);
    int       gap;
    verdict_t v;
    gap = gap_on ? $urandom_range(19) : 0;
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    smp.valid    <= 1'b1;
    smp.accel_x  <= s.ax;
    smp.accel_y  <= s.ay;
    smp.accel_z  <= s.az;
    smp.tilt_cos <= s.tilt;
    @(posedge clk_i);
    while (!smp.ready) @(posedge clk_i);
    v = predict_verdict(s);
    pending_verdicts.push_back(typed ? want : v);
    n_samples++;
    @(negedge clk_i);
  endtask

  initial begin : clock_gen
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles <= CYCLE_CAP) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("%0t: run stalled with %0d results outstanding", $time,
             pending_verdicts.size());
    $display("tb_imu_fall_detector_hysteresis NOT OK");
    $finish;
  end

  initial begin : result_side
    verdict_t want;
    int       stall;
    int       beats;
    bit       stall_on;
    res.ready <= 1'b0;
    beats    = 0;
    stall_on = 1'b1;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (beats % 30 == 0) stall_on = ($urandom_range(3) != 0);
      stall = stall_on ? $urandom_range(19) : 0;
      if (stall == 0) begin
        res.ready <= 1'b1;
      end else begin
        // hold the beat back once it shows up
        res.ready <= 1'b0;
        @(posedge clk_i);
        while (!res.valid) @(posedge clk_i);
        repeat (stall) @(negedge clk_i);
        res.ready <= 1'b1;
      end
      @(posedge clk_i);
      while (!res.valid) @(posedge clk_i);
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: result beat with no sample pending", $time);
      end else begin
        want = pending_verdicts.pop_front();
        check_field("is_falling", 32'(want.falling), 32'(res.is_falling));
        check_field("priority_valid", 32'(want.announce), 32'(res.priority_valid));
        check_field("priority_level", 32'(want.level), 32'(res.priority_level));
        check_field("short_mean", 32'(want.mean), 32'(res.short_mean));
      end
      beats++;
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    row_t      plan [$];
    run_kind_e kind;
    int        run_left;
    int        pick;
    rst_ni       <= 1'b0;
    cfg_valid_i  <= 1'b0;
    cfg_index_i  <= '0;
    cfg_data_i   <= '0;
    smp.valid    <= 1'b0;
    smp.accel_x  <= '0;
    smp.accel_y  <= '0;
    smp.accel_z  <= '0;
    smp.tilt_cos <= '0;
    mismatches   = 0;
    n_samples    = 0;
    n_writes     = 0;
    n_falls      = 0;
    n_recoveries = 0;
    gap_on       = 1'b1;
    reset_model();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    plan = '{
      checked_row(0, 0, 2560, 16384, 0, 0, 0, 2560),
      sample_row(-32768, -32768, -32768, 16384),
      sample_row(32767, 32767, 32767, 16384),
      sample_row(-32768, 32767, 0, -32768),       // tilt past range, mean too high
      sample_row(0, 0, 0, 32767),
      sample_row(0, 0, 0, 8192),
      sample_row(0, 0, 0, 8192),
      sample_row(0, 0, 0, 8192),
      checked_row(0, 0, 0, 8192, 0, 0, 0, 0),     // tilt right on the fall limit
      checked_row(0, 0, 0, 8191, 1, 1, 100, 0),
      checked_row(0, 0, 0, -16384, 1, 0, 0, 0),
      checked_row(0, 0, 0, 13000, 1, 0, 0, 0),    // tilt right on the recovery limit
      sample_row(0, 0, 2560, 32767),              // long mean outside the band
      write_row(imu_fd_pkg::REG_REC_LOW, 0),
      write_row(imu_fd_pkg::REG_REC_HIGH, 65535),
      sample_row(0, 0, 2560, 13001),
      write_row(imu_fd_pkg::REG_FALL_COS, 16384),
      write_row(imu_fd_pkg::REG_REC_COS, -16384),
      write_row(imu_fd_pkg::REG_FALL_ACCEL, 65535),
      write_row(imu_fd_pkg::REG_FALL_PRIO, 255),
      sample_row(0, 0, 0, 0),                     // falls and recovers on one sample
      write_row(imu_fd_pkg::REG_FALL_ACCEL, 0),
      write_row(REG_SPARE_6, 65535),
      write_row(REG_SPARE_7, 4660),
      sample_row(0, 0, 0, -16384),
      write_row(imu_fd_pkg::REG_FALL_ACCEL, 65535),
      write_row(imu_fd_pkg::REG_FALL_COS, -16384),
      sample_row(0, 0, 0, -16385),
      sample_row(1, -1, 1, -32768)
    };
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        wait_idle();
        write_reg(plan[i].idx, plan[i].data);
        cfg_valid_i <= 1'b0;
      end else begin
        put_sample(plan[i].smp_v, plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: program_limits(imu_fd_pkg::FALL_COS_RST, imu_fd_pkg::FALL_ACCEL_RST,
                          imu_fd_pkg::REC_COS_RST, imu_fd_pkg::REC_LOW_RST,
                          imu_fd_pkg::REC_HIGH_RST, {8'h00, imu_fd_pkg::FALL_PRIO_RST});
        // fall and recovery both fire on nearly every tilted sample, so the flag stays clear
        1: program_limits(16'h4000, 16'hFFFF, 16'hC000, 16'h0000, 16'hFFFF,
                          16'($urandom_range(255)));
        2: begin
          write_reg(REG_SPARE_6, 16'($urandom));
          write_reg(REG_SPARE_7, 16'($urandom));
          program_limits(16'hC000, 16'h0000, 16'h4000, 16'hFFFF, 16'h0000, 16'h0000);
        end
        default: program_limits(
          ($urandom_range(3) == 0) ? 16'($urandom) : 16'(between(0, 12000)),
          16'(between(600, 2200)),
          ($urandom_range(3) == 0) ? 16'($urandom) : 16'(between(9000, 16000)),
          16'(between(1800, 2500)),
          16'(between(2600, 3400)),
          ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(255)));
      endcase
      run_left = 0;
      kind     = RUN_UPRIGHT;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          pick = between(0, 99);
          if (pick < 35) kind = RUN_UPRIGHT;
          else if (pick < 60) kind = RUN_FREE_FALL;
          else if (pick < 88) kind = RUN_LYING;
          else kind = RUN_NOISE;
          run_left = (kind == RUN_NOISE) ? between(1, 3) : between(5, 40);
          gap_on   = ($urandom_range(3) != 0);
        end
        run_left--;
        if ($urandom_range(59) == 0) wait_idle();
        put_sample(make_sample(kind), 1'b0, '0);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("%0d samples checked across %0d limit settings, %0d register writes",
             n_samples, PHASES, n_writes);
    $display("%0d falls and %0d recoveries announced", n_falls, n_recoveries);
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("tb_imu_fall_detector_hysteresis OK");
    end else begin
      $display("tb_imu_fall_detector_hysteresis NOT OK");
    end
    $finish;
  end

endmodule
